// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define IAT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define IAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/iat_pkg.sv =====
// Types and constants of the interleave address translator.
package iat_pkg;

    localparam int unsigned FieldW   = 52;  // width of address fields on the ports
    localparam int unsigned WordW    = 64;  // internal address arithmetic width
    localparam int unsigned DivW     = 56;  // divide-by-3 operand width
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 4;

    typedef logic [FieldW-1:0] t_field;
    typedef logic [WordW-1:0]  t_word;

    // register indexes of the config port
    localparam logic [CfgIdxW-1:0] CfgGranularity = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgWays        = 2'd1;

    // ways codes
    localparam logic [3:0] Ways1  = 4'd0;
    localparam logic [3:0] Ways2  = 4'd1;
    localparam logic [3:0] Ways4  = 4'd2;
    localparam logic [3:0] Ways8  = 4'd3;
    localparam logic [3:0] Ways16 = 4'd4;
    localparam logic [3:0] Ways3  = 4'd8;
    localparam logic [3:0] Ways6  = 4'd9;
    localparam logic [3:0] Ways12 = 4'd10;

    typedef struct packed {
        logic [2:0] granularity_code;
        logic [3:0] ways_code;
    } t_cfg;

    typedef struct packed {
        t_field result_address;
        t_field xor_address;
        logic   round_trip_ok;
        logic   error;
    } t_result;

endpackage

// ===== sv/iat_if.sv =====
// Channel interfaces: request, response and config write.
interface iat_req_if;
    import iat_pkg::*;
    logic       valid;
    logic       ready;
    logic       opcode;
    t_field     address;
    logic [3:0] position;
    modport source (output valid, opcode, address, position, input ready);
    modport sink   (input valid, opcode, address, position, output ready);
endinterface

interface iat_rsp_if;
    import iat_pkg::*;
    logic   valid;
    logic   ready;
    t_field result_address;
    t_field xor_address;
    logic   round_trip_ok;
    logic   error;
    modport source (output valid, result_address, xor_address, round_trip_ok, error,
                    input ready);
    modport sink   (input valid, result_address, xor_address, round_trip_ok, error,
                    output ready);
endinterface

interface iat_cfg_if;
    import iat_pkg::*;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/iat_cfg.sv =====
// Configuration registers: granularity and ways codes.
module iat_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iat_cfg_if.sink       i_cfg,
    output iat_pkg::t_cfg o_cfg
);
    import iat_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign i_cfg.ready = i_rst_n;
    assign wr          = i_cfg.valid && i_cfg.ready;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            case (i_cfg.index)
                CfgGranularity: r_cfg.granularity_code <= i_cfg.data[2:0];
                CfgWays:        r_cfg.ways_code        <= i_cfg.data;
                default:        ;  // no register at this index
            endcase
        end
    end

endmodule

// ===== sv/iat_div3.sv =====
// Combinational divide by three of a 56-bit value.
module iat_div3 (
    input  logic [iat_pkg::DivW-1:0] i_dividend,
    output logic [iat_pkg::DivW-1:0] o_quotient
);
    import iat_pkg::*;

    localparam int unsigned HalfW = DivW / 2;
    // (2^HalfW - 1) / 3, so that 2^HalfW = 3*K + 1
    localparam logic [HalfW-1:0] K = HalfW'(((64'd1 << HalfW) - 64'd1) / 64'd3);
    localparam logic [31:0] Magic = 32'hAAAA_AAAB;  // ceil(2^33 / 3)

    logic [HalfW-1:0]   hi, lo;
    logic [HalfW:0]     sum;
    logic [DivW-1:0]    hi_k;
    logic [63:0]        sum_prod;
    logic [HalfW-1:0]   sum_q;

    // x = hi*2^H + lo = 3*hi*K + (hi + lo)  =>  x/3 = hi*K + (hi + lo)/3
    assign hi       = i_dividend[DivW-1:HalfW];
    assign lo       = i_dividend[HalfW-1:0];
    assign sum      = {1'b0, hi} + {1'b0, lo};
    assign hi_k     = DivW'(hi) * DivW'(K);
    assign sum_prod = 64'(32'(sum)) * 64'(Magic);
    assign sum_q    = HalfW'(sum_prod[63:33]);
    assign o_quotient = hi_k + DivW'(sum_q);

endmodule

// ===== sv/iat_xlate.sv =====
// Translation datapath: decode, encode, XOR restore, round-trip check.
module iat_xlate #(
    parameter int unsigned ADDR_BITS = 52
) (
    input  logic               i_opcode,
    input  iat_pkg::t_field    i_address,
    input  logic [3:0]         i_position,
    input  iat_pkg::t_cfg      i_cfg,
    output iat_pkg::t_result   o_result
);
    import iat_pkg::*;

    localparam t_word AddrMask = (ADDR_BITS >= WordW) ? {WordW{1'b1}}
                                 : ((t_word'(1) << ADDR_BITS) - t_word'(1));
    localparam t_word Map0 = 64'h40_4100;
    localparam t_word Map1 = 64'h80_8200;
    localparam t_word Map2 = 64'h101_0400;
    localparam t_word Map3 = 64'h800;
    localparam t_word Map4 = 64'h202_0900;
    localparam t_word Map5 = 64'h404_1200;

    // set the lowest map bit to the parity of the masked address
    function automatic t_word xor_step(input t_word host, input t_word map,
                                       input logic [5:0] lo);
        t_word v;
        v     = host;
        v[lo] = ^(host & map);
        return v;
    endfunction

    function automatic t_word upper(input logic [4:0] lo);
        return AddrMask & ({WordW{1'b1}} << lo);
    endfunction

    logic [2:0]      g;
    logic [3:0]      w;
    logic [3:0]      gran_sh;     // chunk offset bits, 8..15
    logic [1:0]      tri_sh;      // extra power of two for 3/6/12 ways
    logic            is_pow;
    logic            ways_ok, pos_ok;
    logic [4:0]      ways;
    t_word           addr, pos_w, low_mask;
    t_word           enc_upper, enc_low, host_pow, host_tri, host;
    t_word           x1, x2, x3, x4, y1, y2, xr;
    t_word           dec_in, dec_low, dev_pow, up_tri, dev_tri, dec;
    logic [4:0]      tri_total;
    logic [DivW-1:0] quot;

    assign g        = i_cfg.granularity_code;
    assign w        = i_cfg.ways_code;
    assign gran_sh  = {1'b0, g} + 4'd8;
    assign tri_sh   = w[1:0];
    assign is_pow   = (w <= Ways16);
    assign ways_ok  = is_pow || (w >= Ways3 && w <= Ways12);
    assign ways     = is_pow ? (5'd1 << w[2:0]) : (5'd3 << tri_sh);
    assign pos_ok   = ({1'b0, i_position} < ways);

    assign addr     = WordW'(i_address) & AddrMask;
    assign pos_w    = WordW'(i_position);
    assign low_mask = (t_word'(1) << gran_sh) - t_word'(1);

    // encode: device offset + position -> host offset
    assign enc_low   = addr & low_mask;
    assign enc_upper = addr & upper(5'(gran_sh));
    assign host_pow  = (enc_upper << w[2:0]) | (pos_w << gran_sh);
    always_comb begin
        t_word up, up3;
        up       = enc_upper >> gran_sh;
        up3      = up + (up << 1);
        host_tri = ((up3 << tri_sh) + pos_w) << gran_sh;
    end
    assign host = ((is_pow ? host_pow : host_tri) + enc_low) & AddrMask;

    // XOR position restore
    assign x1 = xor_step(host, Map0, 6'd8);
    assign x2 = xor_step(x1,   Map1, 6'd9);
    assign x3 = xor_step(x2,   Map2, 6'd10);
    assign x4 = xor_step(x3,   Map3, 6'd11);
    assign y1 = xor_step(host, Map4, 6'd8);
    assign y2 = xor_step(y1,   Map5, 6'd9);

    always_comb begin
        case (w)
            Ways2:   xr = x1;
            Ways4:   xr = x2;
            Ways8:   xr = x3;
            Ways16:  xr = x4;
            Ways6:   xr = y1;
            Ways12:  xr = y2;
            default: xr = host;
        endcase
    end

    // decode: shared by the decode request and the encode round trip
    assign dec_in    = i_opcode ? host : addr;
    assign dec_low   = dec_in & low_mask;
    assign dev_pow   = (dec_in & upper(5'(gran_sh) + 5'(w[2:0]))) >> w[2:0];
    assign tri_total = 5'(g) + 5'(w);
    assign up_tri    = (dec_in & upper(tri_total)) >> tri_total;

    iat_div3 u_div3 (
        .i_dividend (DivW'(up_tri)),
        .o_quotient (quot)
    );

    assign dev_tri = WordW'(quot) << gran_sh;
    assign dec     = ((is_pow ? dev_pow : dev_tri) + dec_low) & AddrMask;

    always_comb begin
        o_result = '0;
        if (!ways_ok || (i_opcode && !pos_ok)) begin
            o_result.error = 1'b1;
        end else if (!i_opcode) begin
            o_result.result_address = FieldW'(dec);
            o_result.round_trip_ok  = 1'b1;
        end else begin
            o_result.result_address = FieldW'(host);
            o_result.xor_address    = FieldW'(xr & AddrMask);
            o_result.round_trip_ok  = (dec == addr);
        end
    end

endmodule

// ===== sv/interleave_address_translator.sv =====
// Interleave address translator top level: request register, datapath, result register.
//
// Channels: i_req carries one item (opcode, address, position); o_rsp returns
// exactly one result item per request, in order. i_cfg writes the granularity
// code (index 0) and the ways code (index 1); other indexes are ignored.
// Config must be written only while no request is in flight; the block does not check.
// Path: an accepted request is registered in the request stage, translated by the
// combinational datapath and captured in the result register, which drives o_rsp.
// Throughput: one item per cycle while o_rsp is not stalled, set by the single datapath
// pass between the request and result registers (divide by three included).
// Stall: if a valid result sees o_rsp.ready low it holds; one more item still
// enters the request register, then i_req.ready drops until the result leaves.
// Reset (synchronous, active low): both stages empty, config codes zero,
// i_req.ready and i_cfg.ready low while reset is held.
module interleave_address_translator #(
    parameter int unsigned ADDR_BITS = 52   // 40..64, internal address width
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    iat_req_if.sink   i_req,
    iat_rsp_if.source o_rsp,
    iat_cfg_if.sink   i_cfg
);
    import iat_pkg::*;

    t_cfg       cfg;
    t_result    xlate_res;

    // request stage
    logic       r_s1_valid;
    logic       r_s1_opcode;
    t_field     r_s1_address;
    logic [3:0] r_s1_position;

    // result stage
    logic       r_out_valid;
    t_result    r_out;

    logic       accept;
    logic       out_free;
    logic       n_s1_valid;

    iat_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    iat_xlate #(
        .ADDR_BITS (ADDR_BITS)
    ) u_xlate (
        .i_opcode   (r_s1_opcode),
        .i_address  (r_s1_address),
        .i_position (r_s1_position),
        .i_cfg      (cfg),
        .o_result   (xlate_res)
    );

    // result register can take a new item when empty or being drained
    assign out_free    = !r_out_valid || o_rsp.ready;
    // request stage moves on whenever out_free, so it only blocks when full and stuck
    assign i_req.ready = i_rst_n && (!r_s1_valid || out_free);
    assign accept      = i_req.valid && i_req.ready;
    assign n_s1_valid  = accept || (r_s1_valid && !out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_opcode   <= i_req.opcode;
            r_s1_address  <= i_req.address;
            r_s1_position <= i_req.position;
        end
        if (out_free && r_s1_valid) begin
            r_out <= xlate_res;
        end
    end

    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.result_address = r_out.result_address;
    assign o_rsp.xor_address    = r_out.xor_address;
    assign o_rsp.round_trip_ok  = r_out.round_trip_ok;
    assign o_rsp.error          = r_out.error;

endmodule

// ===== sv/iat_checker.sv =====
// Port-level checker for the interleave address translator, with its bind.
`include "assert_macros.svh"

module iat_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_req_valid,
    input logic                  i_req_ready,
    input logic                  i_rsp_valid,
    input logic                  i_rsp_ready,
    input logic [51:0]           i_rsp_result_address,
    input logic [51:0]           i_rsp_xor_address,
    input logic                  i_rsp_round_trip_ok,
    input logic                  i_rsp_error
);

    logic req_acc;
    assign req_acc = i_req_valid && i_req_ready;

    // a rejected item carries an all-zero payload
    `IAT_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, i_rsp_valid && i_rsp_error, i_rsp_result_address == 52'd0 && i_rsp_xor_address == 52'd0 && !i_rsp_round_trip_ok, "error result with nonzero payload")

    // a result appearing on an empty output is an item taken via the request stage
    `IAT_ASSERT_IMPL(a_rise_src, i_clk, i_rst_n, $rose(i_rsp_valid), $past(req_acc, 2), "result without matching request")

    // requests are only refused while a result is stuck at the output
    `IAT_ASSERT_IMPL(a_ready_bp, i_clk, i_rst_n, i_rst_n && !i_req_ready, i_rsp_valid && !i_rsp_ready, "request refused without output stall")

    // a stalled result holds
    `IAT_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_result_address) && $stable(i_rsp_xor_address) && $stable(i_rsp_round_trip_ok) && $stable(i_rsp_error), "stalled result changed")

endmodule

bind interleave_address_translator iat_checker u_iat_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_req_valid          (i_req.valid),
    .i_req_ready          (i_req.ready),
    .i_rsp_valid          (o_rsp.valid),
    .i_rsp_ready          (o_rsp.ready),
    .i_rsp_result_address (o_rsp.result_address),
    .i_rsp_xor_address    (o_rsp.xor_address),
    .i_rsp_round_trip_ok  (o_rsp.round_trip_ok),
    .i_rsp_error          (o_rsp.error)
);
